// ----- rtl/lsbo_pkg.sv -----
// Shared types and codes for the LIFO stack with bulk offset.
// Operation codes, status codes and the controller state type.
// No dependencies.
package lsbo_pkg;

   localparam int WORD_W   = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
   localparam logic [OP_W-1:0] OP_POP     = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB_MAX = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB_MIN = 3'd3;
   localparam logic [OP_W-1:0] OP_ADD_MAX = 3'd4;
   localparam logic [OP_W-1:0] OP_ADD_MIN = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_POP    = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

endpackage

// ----- rtl/lsbo_store.sv -----
// Entry storage for the stack: one write port, one registered read port.
// Read data appears in the cycle after the address. Depends on lsbo_pkg.
module lsbo_store #(
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [AW-1:0]                       wr_addr,
   input  logic signed [lsbo_pkg::WORD_W-1:0]  wr_data,
   input  logic [AW-1:0]                       rd_addr,
   output logic signed [lsbo_pkg::WORD_W-1:0]  rd_data
);

   logic signed [lsbo_pkg::WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/lifo_stack_with_bulk_offset.sv -----
// LIFO stack of signed 32-bit words with bulk add/subtract of the max or min entry.
// Top level: controller, output register; entries live in lsbo_store.
// Depends on lsbo_pkg and lsbo_store.
//
// Usage:
//   req channel: tuser carries the op, tdata the value to push.
//   rsp channel: one item per request with popped data, status and entry count.
//   Push, empty/full errors and unused ops are answered from idle with no other state.
//   Pop: the store read is addressed in idle and its registered data is taken in ST_POP.
//   Bulk ops: one pass over the store finds the extreme, a second pass reads,
//   offsets and writes back each entry. The store has one read and one write
//   port, so each pass moves one entry per cycle.
//   Reset clears the state, the entry count and the output valid flag; store
//   contents are not cleared and only written entries are ever read.
//   A waiting result sits in the output register; the next request is taken
//   in the same cycle that the result is taken. While rsp_tready is low and a
//   result waits, req_tready stays low.
module lifo_stack_with_bulk_offset #(
   parameter int DEPTH = 256,
   localparam int CNT_W       = $clog2(DEPTH + 1),
   localparam int RSP_TDATA_W = ((lsbo_pkg::WORD_W + CNT_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lsbo_pkg::WORD_W-1:0]       req_tdata,   // value
   input  logic [lsbo_pkg::OP_W-1:0]         req_tuser,   // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_TDATA_W-1:0]            rsp_tdata,   // data, count, zero pad
   output logic [lsbo_pkg::STATUS_W-1:0]     rsp_tuser    // status
);

   localparam int AW = $clog2(DEPTH);

   lsbo_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]                     count_ff, count_in;
   logic [CNT_W-1:0]                     rcv_ff, rcv_in;
   logic [lsbo_pkg::OP_W-1:0]            op_ff, op_in;
   logic signed [lsbo_pkg::WORD_W-1:0]   best_ff, best_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [lsbo_pkg::WORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [lsbo_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]                     rsp_count_ff, rsp_count_in;

   logic                                 wr_en;
   logic [AW-1:0]                        wr_addr;
   logic signed [lsbo_pkg::WORD_W-1:0]   wr_data;
   logic [AW-1:0]                        rd_addr;
   logic signed [lsbo_pkg::WORD_W-1:0]   rd_data;

   logic                                 accept;
   logic [CNT_W-1:0]                     count_dec;
   logic [CNT_W-1:0]                     rcv_inc;
   logic [CNT_W-1:0]                     last_idx;
   logic                                 want_max;
   logic                                 do_add;
   logic                                 better;

   lsbo_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == lsbo_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign count_dec  = count_ff - 1'b1;
   assign rcv_inc    = rcv_ff + 1'b1;
   assign last_idx   = count_dec;
   assign want_max   = (op_ff == lsbo_pkg::OP_SUB_MAX) || (op_ff == lsbo_pkg::OP_ADD_MAX);
   assign do_add     = (op_ff == lsbo_pkg::OP_ADD_MAX) || (op_ff == lsbo_pkg::OP_ADD_MIN);
   assign better     = want_max ? (rd_data > best_ff) : (rd_data < best_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rcv_in        = rcv_ff;
      op_in         = op_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = $signed(req_tdata);
      rd_addr       = rcv_inc[AW-1:0];

      case (state_ff)
         lsbo_pkg::ST_IDLE: begin
            if (accept) begin
               op_in         = req_tuser;
               rsp_data_in   = '0;
               rsp_status_in = lsbo_pkg::STATUS_OK;
               rsp_count_in  = count_ff;
               case (req_tuser) inside
                  lsbo_pkg::OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = lsbo_pkg::STATUS_FULL;
                     end else begin
                        wr_en        = 1'b1;
                        count_in     = count_ff + 1'b1;
                        rsp_count_in = count_ff + 1'b1;
                     end
                  end
                  lsbo_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lsbo_pkg::STATUS_EMPTY;
                     end else begin
                        rd_addr  = count_dec[AW-1:0];
                        count_in = count_dec;
                        state_in = lsbo_pkg::ST_POP;
                     end
                  end
                  lsbo_pkg::OP_SUB_MAX, lsbo_pkg::OP_SUB_MIN,
                  lsbo_pkg::OP_ADD_MAX, lsbo_pkg::OP_ADD_MIN: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lsbo_pkg::STATUS_EMPTY;
                     end else begin
                        rd_addr  = '0;
                        rcv_in   = '0;
                        state_in = lsbo_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         lsbo_pkg::ST_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = rd_data;
            rsp_status_in = lsbo_pkg::STATUS_OK;
            rsp_count_in  = count_ff;
            state_in      = lsbo_pkg::ST_IDLE;
         end
         lsbo_pkg::ST_SCAN: begin
            if ((rcv_ff == '0) || better) begin
               best_in = rd_data;
            end
            rcv_in = rcv_inc;
            if (rcv_ff == last_idx) begin
               rd_addr  = '0;
               rcv_in   = '0;
               state_in = lsbo_pkg::ST_UPDATE;
            end
         end
         lsbo_pkg::ST_UPDATE: begin
            wr_en   = 1'b1;
            wr_addr = rcv_ff[AW-1:0];
            wr_data = do_add ? (rd_data + best_ff) : (rd_data - best_ff);
            rcv_in  = rcv_inc;
            if (rcv_ff == last_idx) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = lsbo_pkg::STATUS_OK;
               rsp_count_in  = count_ff;
               state_in      = lsbo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsbo_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsbo_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rcv_ff        <= rcv_in;
      op_ff         <= op_in;
      best_ff       <= best_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[lsbo_pkg::WORD_W-1:0]      = rsp_data_ff;
      rsp_tdata[lsbo_pkg::WORD_W +: CNT_W] = rsp_count_ff;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsbo_pkg::ST_POP) |-> !rsp_valid_ff)
      else $error("pop result would overwrite a pending result");

   a_pass_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == lsbo_pkg::ST_SCAN) || (state_ff == lsbo_pkg::ST_UPDATE))
         |-> (rcv_ff < count_ff))
      else $error("bulk pass index beyond entry count");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == lsbo_pkg::OP_PUSH) && (count_ff != CNT_W'(DEPTH)))
         |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not advance entry count");

endmodule

// ----- tb/sv/lsbo_result_checker.sv -----
// Result checker for the LIFO stack with bulk offset: watches both streams,
// keeps its own copy of the stack, predicts each result and compares it.
// Depends on lsbo_pkg.
module lsbo_result_checker
   import lsbo_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int RSP_W = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [WORD_W-1:0]    req_tdata,    // value
   input  logic [OP_W-1:0]      req_tuser,    // op
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_W-1:0]     rsp_tdata,    // data, count, zero pad
   input  logic [STATUS_W-1:0]  rsp_tuser,    // status
   output int unsigned          mismatches,
   output int unsigned          results_owed
);

   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [WORD_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } stack_result_type;

   logic signed [WORD_W-1:0] stack_words [DEPTH];
   int unsigned              stack_fill = 0;
   stack_result_type         owed_results [$];
   int unsigned              error_total = 0;
   int unsigned              result_index = 0;

   function automatic stack_result_type apply_stack_op(input logic [OP_W-1:0] op,
                                                       input logic [WORD_W-1:0] value);
      stack_result_type         res;
      logic signed [WORD_W-1:0] extreme;
      bit                       want_max;
      res = '0;
      case (op)
         OP_PUSH: begin
            if (stack_fill >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               stack_words[stack_fill] = value;
               stack_fill++;
            end
         end
         OP_POP: begin
            if (stack_fill == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               stack_fill--;
               res.data = stack_words[stack_fill];
            end
         end
         OP_SUB_MAX, OP_SUB_MIN, OP_ADD_MAX, OP_ADD_MIN: begin
            if (stack_fill == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               want_max = (op == OP_SUB_MAX) || (op == OP_ADD_MAX);
               extreme  = stack_words[0];
               for (int i = 1; i < stack_fill; i++) begin
                  if (want_max ? (stack_words[i] > extreme) : (stack_words[i] < extreme))
                     extreme = stack_words[i];
               end
               for (int i = 0; i < stack_fill; i++) begin
                  if ((op == OP_ADD_MAX) || (op == OP_ADD_MIN))
                     stack_words[i] = stack_words[i] + extreme;
                  else
                     stack_words[i] = stack_words[i] - extreme;
               end
            end
         end
         default: ;
      endcase
      res.count = stack_fill[COUNT_W-1:0];
      return res;
   endfunction

   function automatic int check_field(input string name, input logic [WORD_W-1:0] expected,
                                      input logic [WORD_W-1:0] actual);
      if (expected === actual)
         return 0;
      $display("%0t: result %0d %s expected %h actual %h",
               $time, result_index, name, expected, actual);
      return 1;
   endfunction

   always @(posedge clock) begin : monitor
      stack_result_type want;
      stack_result_type got;
      if (reset) begin
         stack_fill = 0;
         owed_results.delete();
      end else begin
         // request first: a result never belongs to an item taken in the same cycle
         if (req_tvalid && req_tready)
            owed_results.push_back(apply_stack_op(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.data   = rsp_tdata[WORD_W-1:0];
            got.count  = rsp_tdata[WORD_W+COUNT_W-1:WORD_W];
            got.status = rsp_tuser;
            if (owed_results.size() == 0) begin
               $display("%0t: result %0d with none expected: data %h status %0d count %0d",
                        $time, result_index, got.data, got.status, got.count);
               error_total++;
            end else begin
               want = owed_results.pop_front();
               error_total += check_field("data", want.data, got.data);
               error_total += check_field("status", want.status, got.status);
               error_total += check_field("count", want.count, got.count);
            end
            result_index++;
         end
      end
      mismatches   <= error_total;
      results_owed <= owed_results.size();
   end

endmodule

// ----- tb/sv/lifo_stack_with_bulk_offset_test.sv -----
// Top of the LIFO stack test: clock, reset, request and result stimulus, verdict.
// Directed corner items, then push/pop/bulk phases with bursty traffic.
// Depends on lsbo_pkg, lifo_stack_with_bulk_offset and lsbo_result_checker.
module lifo_stack_with_bulk_offset_test;
   import lsbo_pkg::*;

   localparam int DEPTH       = 256;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int RSP_W       = ((WORD_W + COUNT_W + 7) / 8) * 8;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 4 * DEPTH;

   localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

   typedef enum {PH_MIX, PH_FILL, PH_DRAIN} phase_type;
   typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_RARELY} ready_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [WORD_W-1:0]   req_tdata = '0;      // value
   logic [OP_W-1:0]     req_tuser = OP_PUSH; // op
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;           // data, count, zero pad
   logic [STATUS_W-1:0] rsp_tuser;           // status

   int unsigned mismatches;
   int unsigned results_owed;
   int unsigned stuck_cycles = 0;
   int unsigned burst_left = 0;

   always #5 clock = ~clock;

   lifo_stack_with_bulk_offset #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lsbo_result_checker #(.DEPTH(DEPTH), .RSP_W(RSP_W)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .mismatches   (mismatches),
      .results_owed (results_owed)
   );

   // called at a rising edge; returns at the edge that takes the item, or later after a random idle gap
   task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [OP_W-1:0] pick_bulk();
      case ($urandom_range(0, 3))
         0:       return OP_SUB_MAX;
         1:       return OP_SUB_MIN;
         2:       return OP_ADD_MAX;
         default: return OP_ADD_MIN;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input phase_type phase);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (phase)
         PH_FILL:  return (roll < 97) ? OP_PUSH : pick_bulk();
         PH_DRAIN: return (roll < 97) ? OP_POP : pick_bulk();
         default: begin
            if (roll < 45) return OP_PUSH;
            if (roll < 80) return OP_POP;
            if (roll < 96) return pick_bulk();
            return (roll < 98) ? OP_RSVD_6 : OP_RSVD_7;
         end
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:          return 32'h7fff_ffff;
         1:          return 32'h8000_0000;
         2:          return '0;
         3:          return '1;
         4, 5, 6:    return WORD_W'($urandom_range(0, 511)) - 32'd256;
         default:    return $urandom;
      endcase
   endfunction

   task automatic run_phase(input phase_type phase, input int unsigned items);
      repeat (items) send_item(pick_op(phase), pick_value());
   endtask

   // receiver: changing ready patterns, plus one long hold-off to back up the request side
   initial begin : receiver
      ready_mode_type mode;
      int unsigned    mode_left;
      int unsigned    hold_left;
      int unsigned    taken;
      bit             held;
      mode      = READY_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      taken     = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            taken++;
         if (!held && taken >= 150) begin
            hold_left = 600;
            held      = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(8, 80);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
               default:      rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty stack: pop, every bulk op, spare codes
      send_item(OP_POP, 32'h1234_5678);
      send_item(OP_SUB_MAX, '1);
      send_item(OP_SUB_MIN, '0);
      send_item(OP_ADD_MAX, 32'h8000_0000);
      send_item(OP_ADD_MIN, 32'h7fff_ffff);
      send_item(OP_RSVD_6, 32'h5555_5555);
      send_item(OP_RSVD_7, 32'haaaa_aaaa);
      // extremes, then bulk ops that wrap
      send_item(OP_PUSH, 32'h7fff_ffff);
      send_item(OP_PUSH, 32'h8000_0000);
      send_item(OP_PUSH, '1);
      send_item(OP_PUSH, '0);
      send_item(OP_ADD_MAX, 32'hdead_beef);
      send_item(OP_SUB_MIN, '0);
      send_item(OP_ADD_MIN, '0);
      send_item(OP_SUB_MAX, '0);
      send_item(OP_RSVD_6, '0);
      send_item(OP_POP, '0);
      send_item(OP_POP, '0);

      run_phase(PH_MIX, 200);
      run_phase(PH_FILL, 300);
      run_phase(PH_MIX, 100);
      run_phase(PH_DRAIN, 300);
      run_phase(PH_MIX, 50);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lsbo_pkg.sv
rtl/lsbo_store.sv
rtl/lifo_stack_with_bulk_offset.sv
tb/sv/lsbo_result_checker.sv
tb/sv/lifo_stack_with_bulk_offset_test.sv
